// File: src/bpsp_pkg.sv
package bpsp_pkg;

  // Default limit on image width and height.
  localparam int unsigned MAX_DIMENSION_DEF = 4096;

  // Widths of the result fields.
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned COLOR_W = 8;

  // Header layout: byte positions at which a little-endian field is complete.
  localparam logic [31:0] POS_SIGNATURE   = 32'd1;
  localparam logic [31:0] POS_OFFSET      = 32'd13;
  localparam logic [31:0] POS_WIDTH       = 32'd21;
  localparam logic [31:0] POS_HEIGHT      = 32'd25;
  localparam logic [31:0] POS_DEPTH       = 32'd29;
  localparam logic [31:0] POS_HEADER_END  = 32'd53;
  localparam logic [31:0] POS_PIXEL_START = 32'd54;

  localparam logic [15:0] SIGNATURE = 16'h4D42;
  localparam logic [15:0] DEPTH_24  = 16'd24;
  localparam logic [15:0] DEPTH_32  = 16'd32;

  localparam logic [COLOR_W-1:0] COLOR_BLACK = 8'h00;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 8'hFF;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SKIP    = 3'd1,
    PH_PIXELS  = 3'd2,
    PH_PADDING = 3'd3,
    PH_DONE    = 3'd4,
    PH_HALT    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_SIGNATURE = 3'd0,
    ERR_DEPTH     = 3'd1,
    ERR_TOO_LARGE = 3'd2,
    ERR_OFFSET    = 3'd3,
    ERR_NOT_BW    = 3'd4
  } err_e;

  // One result as it travels from the parser to the output buffer.
  typedef struct packed {
    kind_e              kind;
    err_e               code;
    logic [PIX_W-1:0]   row;
    logic [PIX_W-1:0]   col;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
    logic               last;
  } result_t;

endpackage

// File: src/bpsp_parse_core.sv
module bpsp_parse_core #(
  parameter int unsigned MAX_DIMENSION = bpsp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [bpsp_pkg::COLOR_W-1:0]      data_byte_i,
  input  logic                              file_start_i,
  output logic                              push_o,
  output bpsp_pkg::result_t                 result_o
);

  localparam int unsigned DimW = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned ExtW = (DimW > bpsp_pkg::PIX_W) ? DimW : bpsp_pkg::PIX_W;

  bpsp_pkg::phase_e phase_q, phase_d, phase_cur;
  logic [31:0] pos_q, pos_d, pos_cur;
  logic [31:0] shift_q, shift_d, shift_cur, shift_new;
  logic [31:0] offset_q, offset_d;
  logic [DimW-1:0] width_q, width_d, height_q, height_d;
  logic [DimW-1:0] row_q, row_d, col_q, col_d;
  logic [DimW-1:0] row_next, col_next, row_top, dim_value;
  logic alpha_q, alpha_d;
  logic [1:0] bip_q, bip_d, pad_q, pad_d, pad_dec, last_bip;
  logic [bpsp_pkg::COLOR_W-1:0] blue_q, blue_d, green_q, green_d, red_q, red_d;
  logic [bpsp_pkg::COLOR_W-1:0] red_now, alpha_now;
  logic [ExtW-1:0] row_ext, col_ext, width_ext;
  logic dim_empty, dim_big, is_bw, do_pixel;

  // A start mark restarts the header walk with this byte as byte zero.
  assign phase_cur = file_start_i ? bpsp_pkg::PH_HEADER : phase_q;
  assign pos_cur   = file_start_i ? 32'd0 : pos_q;
  assign shift_cur = file_start_i ? 32'd0 : shift_q;
  assign shift_new = {data_byte_i, shift_cur[31:8]};

  // Dimension decode: zero or negative is empty, above the limit is an error.
  assign dim_empty = (shift_new == 32'd0) || shift_new[31];
  assign dim_big   = !dim_empty && (shift_new > 32'(MAX_DIMENSION));
  assign dim_value = dim_empty ? '0 : shift_new[DimW-1:0];

  // Row and column arithmetic.
  assign row_next  = row_q + 1'b1;
  assign col_next  = col_q + 1'b1;
  assign row_top   = height_q - row_next;
  assign row_ext   = ExtW'(row_top);
  assign col_ext   = ExtW'(col_q);
  assign width_ext = ExtW'(width_q);

  // Pixel assembly and the black-or-white check.
  assign last_bip  = alpha_q ? 2'd3 : 2'd2;
  assign red_now   = (bip_q == 2'd2) ? data_byte_i : red_q;
  assign alpha_now = (bip_q == 2'd3) ? data_byte_i : bpsp_pkg::COLOR_BLACK;
  assign is_bw = ((red_now == bpsp_pkg::COLOR_BLACK) && (green_q == bpsp_pkg::COLOR_BLACK) &&
                  (blue_q == bpsp_pkg::COLOR_BLACK)) ||
                 ((red_now == bpsp_pkg::COLOR_WHITE) && (green_q == bpsp_pkg::COLOR_WHITE) &&
                  (blue_q == bpsp_pkg::COLOR_WHITE));
  assign pad_dec = (pad_q != 2'd0) ? pad_q - 2'd1 : pad_q;

  // Next state and result for one accepted byte.
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    shift_d  = shift_q;
    offset_d = offset_q;
    width_d  = width_q;
    height_d = height_q;
    alpha_d  = alpha_q;
    row_d    = row_q;
    col_d    = col_q;
    bip_d    = bip_q;
    pad_d    = pad_q;
    blue_d   = blue_q;
    green_d  = green_q;
    red_d    = red_q;
    do_pixel = 1'b0;
    push_o   = 1'b0;
    result_o.kind  = bpsp_pkg::KIND_PIXEL;
    result_o.code  = bpsp_pkg::ERR_SIGNATURE;
    result_o.row   = '0;
    result_o.col   = '0;
    result_o.red   = '0;
    result_o.green = '0;
    result_o.blue  = '0;
    result_o.alpha = '0;
    result_o.last  = 1'b0;

    if (accept_i) begin
      phase_d = phase_cur;
      pos_d   = pos_cur;
      shift_d = shift_cur;
      case (phase_cur)
        bpsp_pkg::PH_HEADER: begin
          shift_d = shift_new;
          pos_d   = pos_cur + 32'd1;
          row_d   = '0;
          col_d   = '0;
          bip_d   = '0;
          if (pos_cur == bpsp_pkg::POS_SIGNATURE) begin
            if (shift_new[31:16] != bpsp_pkg::SIGNATURE) begin
              push_o        = 1'b1;
              result_o.kind = bpsp_pkg::KIND_ERROR;
              result_o.code = bpsp_pkg::ERR_SIGNATURE;
              phase_d       = bpsp_pkg::PH_HALT;
            end
          end else if (pos_cur == bpsp_pkg::POS_OFFSET) begin
            offset_d = shift_new;
          end else if (pos_cur == bpsp_pkg::POS_WIDTH) begin
            if (dim_big) begin
              push_o        = 1'b1;
              result_o.kind = bpsp_pkg::KIND_ERROR;
              result_o.code = bpsp_pkg::ERR_TOO_LARGE;
              phase_d       = bpsp_pkg::PH_HALT;
            end else begin
              width_d = dim_value;
            end
          end else if (pos_cur == bpsp_pkg::POS_HEIGHT) begin
            if (dim_big) begin
              push_o        = 1'b1;
              result_o.kind = bpsp_pkg::KIND_ERROR;
              result_o.code = bpsp_pkg::ERR_TOO_LARGE;
              phase_d       = bpsp_pkg::PH_HALT;
            end else begin
              height_d = dim_value;
            end
          end else if (pos_cur == bpsp_pkg::POS_DEPTH) begin
            if (shift_new[31:16] == bpsp_pkg::DEPTH_24) begin
              alpha_d = 1'b0;
            end else if (shift_new[31:16] == bpsp_pkg::DEPTH_32) begin
              alpha_d = 1'b1;
            end else begin
              push_o        = 1'b1;
              result_o.kind = bpsp_pkg::KIND_ERROR;
              result_o.code = bpsp_pkg::ERR_DEPTH;
              phase_d       = bpsp_pkg::PH_HALT;
            end
          end else if (pos_cur == bpsp_pkg::POS_HEADER_END) begin
            if ((width_q == '0) || (height_q == '0)) begin
              push_o        = 1'b1;
              result_o.kind = bpsp_pkg::KIND_EMPTY;
              phase_d       = bpsp_pkg::PH_DONE;
            end else if (offset_q < bpsp_pkg::POS_PIXEL_START) begin
              push_o        = 1'b1;
              result_o.kind = bpsp_pkg::KIND_ERROR;
              result_o.code = bpsp_pkg::ERR_OFFSET;
              phase_d       = bpsp_pkg::PH_HALT;
            end else if (offset_q == bpsp_pkg::POS_PIXEL_START) begin
              phase_d = bpsp_pkg::PH_PIXELS;
            end else begin
              phase_d = bpsp_pkg::PH_SKIP;
            end
          end
        end
        bpsp_pkg::PH_SKIP: begin
          if (pos_cur != offset_q) begin
            pos_d = pos_cur + 32'd1;
          end else begin
            do_pixel = 1'b1;
          end
        end
        bpsp_pkg::PH_PIXELS: begin
          do_pixel = 1'b1;
        end
        bpsp_pkg::PH_PADDING: begin
          pad_d = pad_dec;
          if (pad_dec == 2'd0) begin
            col_d   = '0;
            row_d   = row_next;
            phase_d = (row_next >= height_q) ? bpsp_pkg::PH_DONE : bpsp_pkg::PH_PIXELS;
          end
        end
        default: begin
        end
      endcase

      // Pixel bytes arrive blue, green, red and, for 32-bit images, alpha.
      if (do_pixel) begin
        phase_d = bpsp_pkg::PH_PIXELS;
        case (bip_q)
          2'd0:    blue_d  = data_byte_i;
          2'd1:    green_d = data_byte_i;
          2'd2:    red_d   = data_byte_i;
          default: begin
          end
        endcase
        if (bip_q != last_bip) begin
          bip_d = bip_q + 2'd1;
        end else begin
          bip_d  = 2'd0;
          push_o = 1'b1;
          if (!is_bw) begin
            result_o.kind = bpsp_pkg::KIND_ERROR;
            result_o.code = bpsp_pkg::ERR_NOT_BW;
            phase_d       = bpsp_pkg::PH_HALT;
          end else begin
            result_o.row   = row_ext[bpsp_pkg::PIX_W-1:0];
            result_o.col   = col_ext[bpsp_pkg::PIX_W-1:0];
            result_o.red   = red_now;
            result_o.green = green_q;
            result_o.blue  = blue_q;
            result_o.alpha = alpha_now;
            result_o.last  = (row_next == height_q) && (col_next == width_q);
            col_d          = col_next;
            // End of a row: take the padding if any, else move up a row.
            if (col_next >= width_q) begin
              if (!alpha_q && (width_ext[1:0] != 2'd0)) begin
                pad_d   = width_ext[1:0];
                phase_d = bpsp_pkg::PH_PADDING;
              end else begin
                col_d   = '0;
                row_d   = row_next;
                phase_d = (row_next >= height_q) ? bpsp_pkg::PH_DONE : bpsp_pkg::PH_PIXELS;
              end
            end
          end
        end
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= bpsp_pkg::PH_HEADER;
      pos_q    <= '0;
      shift_q  <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      alpha_q  <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      bip_q    <= '0;
      pad_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      alpha_q  <= alpha_d;
      row_q    <= row_d;
      col_q    <= col_d;
      bip_q    <= bip_d;
      pad_q    <= pad_d;
    end
  end

  // Saved color bytes; always written before they are read.
  always_ff @(posedge clk_i) begin
    blue_q  <= blue_d;
    green_q <= green_d;
    red_q   <= red_d;
  end

endmodule

// File: src/bpsp_out_buffer.sv
module bpsp_out_buffer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bpsp_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpsp_pkg::result_t out_data_o
);

  logic              main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;
  bpsp_pkg::result_t main_q, main_d, skid_q, skid_d;
  logic              main_free;

  // The main register can take new data when empty or being drained.
  assign main_free   = !main_valid_q || out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // Refill order: skid entry first, then the new result.
  always_comb begin
    main_valid_d = main_valid_q;
    main_d       = main_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// File: src/bmp_pixel_stream_parser.sv
// Streaming parser for 24- and 32-bit BMP files that takes one file byte per
// cycle and returns at most one result per byte: a pixel with its top-down row
// and column, an empty-image marker, or an error that stops the parse until the
// next byte flagged with file_start_i. Each byte updates the header, skip and
// row counters in the same cycle it is accepted, so a new byte can be taken on
// every clock while in_ready_o is high. Results leave through a two-entry output
// buffer; in_ready_o drops only while both entries hold results that have
// not been taken. A result appears on the outputs the cycle after the byte that
// completes it, unless older results are still waiting in the buffer.
module bmp_pixel_stream_parser #(
  parameter int unsigned MAX_DIMENSION = bpsp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                file_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          result_kind_o,
  output logic [2:0]                          error_code_o,
  output logic [bpsp_pkg::PIX_W-1:0]          pixel_row_o,
  output logic [bpsp_pkg::PIX_W-1:0]          pixel_column_o,
  output logic [bpsp_pkg::COLOR_W-1:0]        red_value_o,
  output logic [bpsp_pkg::COLOR_W-1:0]        green_value_o,
  output logic [bpsp_pkg::COLOR_W-1:0]        blue_value_o,
  output logic [bpsp_pkg::COLOR_W-1:0]        alpha_value_o,
  output logic                                last_pixel_o
);

  logic              accept, push;
  bpsp_pkg::result_t result, out_data;

  // A byte transaction completes when valid meets a free buffer slot.
  assign accept = in_valid_i && in_ready_o;

  bpsp_parse_core #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_parse_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .push_o       (push),
    .result_o     (result)
  );

  bpsp_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  // Unpack the result onto the output ports.
  assign result_kind_o  = out_data.kind;
  assign error_code_o   = out_data.code;
  assign pixel_row_o    = out_data.row;
  assign pixel_column_o = out_data.col;
  assign red_value_o    = out_data.red;
  assign green_value_o  = out_data.green;
  assign blue_value_o   = out_data.blue;
  assign alpha_value_o  = out_data.alpha;
  assign last_pixel_o   = out_data.last;

endmodule

// File: src/bpsp_checker.sv
module bpsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   result_kind_o,
  input logic [2:0]                   error_code_o,
  input logic [bpsp_pkg::PIX_W-1:0]   pixel_row_o,
  input logic [bpsp_pkg::PIX_W-1:0]   pixel_column_o,
  input logic [bpsp_pkg::COLOR_W-1:0] red_value_o,
  input logic [bpsp_pkg::COLOR_W-1:0] green_value_o,
  input logic [bpsp_pkg::COLOR_W-1:0] blue_value_o,
  input logic [bpsp_pkg::COLOR_W-1:0] alpha_value_o,
  input logic                         last_pixel_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_kind_o) && $stable(error_code_o) &&
      $stable(pixel_row_o) && $stable(pixel_column_o) && $stable(red_value_o) &&
      $stable(green_value_o) && $stable(blue_value_o) && $stable(alpha_value_o) &&
      $stable(last_pixel_o))
    else $error("result payload changed while stalled");

  // Pixel fields are zero on empty-image and error results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != bpsp_pkg::KIND_PIXEL) |->
      (pixel_row_o == '0) && (pixel_column_o == '0) && (red_value_o == '0) &&
      (green_value_o == '0) && (blue_value_o == '0) && (alpha_value_o == '0) &&
      !last_pixel_o)
    else $error("pixel fields set on a non-pixel result");

  // A pixel result has a zero error code and is black or white.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == bpsp_pkg::KIND_PIXEL) |->
      (error_code_o == '0) && (red_value_o == green_value_o) &&
      (green_value_o == blue_value_o) &&
      ((red_value_o == bpsp_pkg::COLOR_BLACK) || (red_value_o == bpsp_pkg::COLOR_WHITE)))
    else $error("pixel result with error code or mixed color");

  // With no result offered the buffer is empty, so input is never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused while no result is waiting");

endmodule

bind bmp_pixel_stream_parser bpsp_checker u_bpsp_checker (.*);

// File: tb/bmp_pixel_stream_parser_test.sv
module bmp_pixel_stream_parser_test;

  localparam int unsigned MAX_DIM = bpsp_pkg::MAX_DIMENSION_DEF;
  localparam int unsigned PIX_W   = bpsp_pkg::PIX_W;

  // Predicts the parser byte by byte and checks the results that come out.
  class pixel_scoreboard;
    bpsp_pkg::phase_e  phase;
    logic [31:0]       byte_pos;
    logic [31:0]       shift_reg;
    logic [31:0]       data_offset;
    int unsigned       width;
    int unsigned       height;
    int unsigned       file_row;
    int unsigned       column;
    bit                has_alpha;
    bit [1:0]          byte_in_pixel;
    bit [1:0]          pad_left;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    bpsp_pkg::result_t pending[$];
    int unsigned       failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      phase         = bpsp_pkg::PH_HEADER;
      byte_pos      = '0;
      shift_reg     = '0;
      data_offset   = '0;
      width         = 0;
      height        = 0;
      file_row      = 0;
      column        = 0;
      has_alpha     = 1'b0;
      byte_in_pixel = '0;
      pad_left      = '0;
      blue          = '0;
      green         = '0;
      red           = '0;
    endfunction

    // Appends one predicted result behind the older ones.
    function void add_result(bpsp_pkg::result_t r);
      pending.insert(pending.size(), r);
    endfunction

    function void halt_with(bpsp_pkg::err_e code);
      bpsp_pkg::result_t r;
      r      = '0;
      r.kind = bpsp_pkg::KIND_ERROR;
      r.code = code;
      add_result(r);
      phase = bpsp_pkg::PH_HALT;
    endfunction

    function void next_row();
      column = 0;
      file_row++;
      phase = (file_row >= height) ? bpsp_pkg::PH_DONE : bpsp_pkg::PH_PIXELS;
    endfunction

    // Collects blue, green, red (and alpha) and emits the finished pixel, or an error if it is neither black nor white.
    function void pixel_byte(logic [7:0] d);
      logic [7:0]        alpha;
      bpsp_pkg::result_t r;
      alpha = '0;
      case (byte_in_pixel)
        2'd0: blue = d;
        2'd1: green = d;
        2'd2: red = d;
        default: alpha = d;
      endcase
      if (byte_in_pixel < (has_alpha ? 2'd3 : 2'd2)) begin
        byte_in_pixel++;
        return;
      end
      byte_in_pixel = '0;
      if (!({red, green, blue} == {3{bpsp_pkg::COLOR_BLACK}} ||
            {red, green, blue} == {3{bpsp_pkg::COLOR_WHITE}})) begin
        halt_with(bpsp_pkg::ERR_NOT_BW);
        return;
      end
      r       = '0;
      r.kind  = bpsp_pkg::KIND_PIXEL;
      r.row   = PIX_W'(height - 1 - file_row);
      r.col   = PIX_W'(column);
      r.red   = red;
      r.green = green;
      r.blue  = blue;
      r.alpha = alpha;
      r.last  = (file_row + 1 == height) && (column + 1 == width);
      add_result(r);
      column++;
      if (column >= width) begin
        // Rows of 24-bit images are padded to a multiple of four bytes.
        if (!has_alpha && width[1:0] != 2'd0) begin
          pad_left = width[1:0];
          phase    = bpsp_pkg::PH_PADDING;
        end else begin
          next_row();
        end
      end
    endfunction

    // Advances the prediction by one accepted byte.
    function void note_byte(logic [7:0] d, logic start);
      logic [31:0]       pos;
      logic [31:0]       dim;
      bpsp_pkg::result_t r;
      if (start) restart();
      case (phase)
        bpsp_pkg::PH_HEADER: begin
          pos       = byte_pos;
          shift_reg = {d, shift_reg[31:8]};
          byte_pos++;
          dim = shift_reg[31] ? 32'd0 : shift_reg;
          if (pos == bpsp_pkg::POS_SIGNATURE) begin
            if (shift_reg[31:16] != bpsp_pkg::SIGNATURE) halt_with(bpsp_pkg::ERR_SIGNATURE);
          end else if (pos == bpsp_pkg::POS_OFFSET) begin
            data_offset = shift_reg;
          end else if (pos == bpsp_pkg::POS_WIDTH) begin
            if (dim > MAX_DIM) halt_with(bpsp_pkg::ERR_TOO_LARGE);
            else width = dim;
          end else if (pos == bpsp_pkg::POS_HEIGHT) begin
            if (dim > MAX_DIM) halt_with(bpsp_pkg::ERR_TOO_LARGE);
            else height = dim;
          end else if (pos == bpsp_pkg::POS_DEPTH) begin
            if (shift_reg[31:16] == bpsp_pkg::DEPTH_24) has_alpha = 1'b0;
            else if (shift_reg[31:16] == bpsp_pkg::DEPTH_32) has_alpha = 1'b1;
            else halt_with(bpsp_pkg::ERR_DEPTH);
          end else if (pos == bpsp_pkg::POS_HEADER_END) begin
            // An empty image wins over a bad pixel-data offset.
            if (width == 0 || height == 0) begin
              r      = '0;
              r.kind = bpsp_pkg::KIND_EMPTY;
              add_result(r);
              phase = bpsp_pkg::PH_DONE;
            end else if (data_offset < bpsp_pkg::POS_PIXEL_START) begin
              halt_with(bpsp_pkg::ERR_OFFSET);
            end else begin
              phase = (data_offset == bpsp_pkg::POS_PIXEL_START) ? bpsp_pkg::PH_PIXELS :
                                                                   bpsp_pkg::PH_SKIP;
            end
          end
        end
        bpsp_pkg::PH_SKIP: begin
          if (byte_pos != data_offset) begin
            byte_pos++;
          end else begin
            phase = bpsp_pkg::PH_PIXELS;
            pixel_byte(d);
          end
        end
        bpsp_pkg::PH_PIXELS: pixel_byte(d);
        bpsp_pkg::PH_PADDING: begin
          if (pad_left > 0) pad_left--;
          if (pad_left == 0) next_row();
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    // Checks one accepted result against the oldest prediction.
    function void check_result(bpsp_pkg::result_t got);
      bpsp_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: kind %0d code %0d", got.kind, got.code);
        failures++;
        return;
      end
      want = pending.pop_front();
      compare("result_kind", want.kind, got.kind);
      compare("error_code", want.code, got.code);
      compare("pixel_row", want.row, got.row);
      compare("pixel_column", want.col, got.col);
      compare("red_value", want.red, got.red);
      compare("green_value", want.green, got.green);
      compare("blue_value", want.blue, got.blue);
      compare("alpha_value", want.alpha, got.alpha);
      compare("last_pixel", want.last, got.last);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     data_byte = '0;
  logic                           file_start = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     result_kind;
  logic [2:0]                     error_code;
  logic [PIX_W-1:0]               pixel_row;
  logic [PIX_W-1:0]               pixel_column;
  logic [bpsp_pkg::COLOR_W-1:0]   red_value;
  logic [bpsp_pkg::COLOR_W-1:0]   green_value;
  logic [bpsp_pkg::COLOR_W-1:0]   blue_value;
  logic [bpsp_pkg::COLOR_W-1:0]   alpha_value;
  logic                           last_pixel;

  pixel_scoreboard   sb;
  logic [7:0]        file_bytes[$];
  int unsigned       send_idle_pct = 16;
  int unsigned       recv_idle_pct = 66;
  int unsigned       sent_count = 0;
  bit                hold_request = 1'b0;
  bit                hold_taken = 1'b0;
  int unsigned       hold_left = 0;
  bit                byte_handshake = 1'b0;
  bit                result_handshake = 1'b0;
  bpsp_pkg::result_t seen;

  bmp_pixel_stream_parser dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .file_start_i   (file_start),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .error_code_o   (error_code),
    .pixel_row_o    (pixel_row),
    .pixel_column_o (pixel_column),
    .red_value_o    (red_value),
    .green_value_o  (green_value),
    .blue_value_o   (blue_value),
    .alpha_value_o  (alpha_value),
    .last_pixel_o   (last_pixel)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("FAIL bmp_pixel_stream_parser");
    $finish;
  end

  // Outputs are stable mid-cycle; decide here what the next rising edge accepts.
  always @(negedge clk) begin
    byte_handshake   = rst_n && in_valid && in_ready;
    result_handshake = rst_n && out_valid && out_ready;
    seen.kind  = bpsp_pkg::kind_e'(result_kind);
    seen.code  = bpsp_pkg::err_e'(error_code);
    seen.row   = pixel_row;
    seen.col   = pixel_column;
    seen.red   = red_value;
    seen.green = green_value;
    seen.blue  = blue_value;
    seen.alpha = alpha_value;
    seen.last  = last_pixel;
  end

  // Result side: checks each transaction, stalls at random or for a long hold.
  initial begin
    forever begin
      @(posedge clk);
      if (result_handshake) sb.check_result(seen);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 250;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Appends one byte to the file being built.
  function automatic void add_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  // Offers one byte, with random gaps before it, and waits for its transaction.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (sent_count < 470) begin
      send_idle_pct = 16;
      recv_idle_pct = 66;
    end else if (sent_count < 940) begin
      send_idle_pct = 66;
      recv_idle_pct = 16;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    file_start <= start;
    do @(posedge clk); while (!byte_handshake);
    sb.note_byte(b, start);
    sent_count++;
  endtask

  // Builds a file: headers, skip bytes, pixel rows when the header is usable, trailing noise.
  task automatic build_file(input logic [15:0] sig, input logic [31:0] offset,
                            input logic [31:0] w_raw, input logic [31:0] h_raw,
                            input logic [15:0] depth, input int unsigned bad_pct,
                            input int unsigned tail);
    logic [7:0]  hdr[54];
    logic [7:0]  shade;
    int unsigned w;
    int unsigned h;
    int unsigned skip;
    int unsigned x;
    int unsigned y;
    file_bytes.delete();
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    {hdr[1], hdr[0]} = sig;
    {hdr[13], hdr[12], hdr[11], hdr[10]} = offset;
    {hdr[21], hdr[20], hdr[19], hdr[18]} = w_raw;
    {hdr[25], hdr[24], hdr[23], hdr[22]} = h_raw;
    {hdr[29], hdr[28]} = depth;
    foreach (hdr[i]) add_byte(hdr[i]);
    w = w_raw[31] ? 0 : w_raw;
    h = h_raw[31] ? 0 : h_raw;
    if (w >= 1 && w <= MAX_DIM && h >= 1 && h <= MAX_DIM &&
        offset >= bpsp_pkg::POS_PIXEL_START &&
        (depth == bpsp_pkg::DEPTH_24 || depth == bpsp_pkg::DEPTH_32)) begin
      // A huge offset only gets a few filler bytes; the parser keeps skipping.
      skip = (offset - bpsp_pkg::POS_PIXEL_START > 16) ? 4 :
                                                         offset - bpsp_pkg::POS_PIXEL_START;
      repeat (skip) add_byte(8'($urandom));
      for (y = 0; y < h; y++) begin
        for (x = 0; x < w; x++) begin
          shade = $urandom_range(1) ? bpsp_pkg::COLOR_WHITE : bpsp_pkg::COLOR_BLACK;
          repeat (3) add_byte(($urandom_range(99) < bad_pct) ? 8'($urandom) : shade);
          if (depth == bpsp_pkg::DEPTH_32) add_byte(8'($urandom));
        end
        if (depth == bpsp_pkg::DEPTH_24) repeat (w % 4) add_byte(8'($urandom));
      end
    end
    repeat (tail) add_byte(8'($urandom));
  endtask

  task automatic send_file(input bit marked, input int unsigned count);
    int unsigned i;
    for (i = 0; i < count && i < file_bytes.size(); i++)
      send_byte(file_bytes[i], marked && i == 0);
  endtask

  task automatic play(input logic [15:0] sig, input logic [31:0] offset,
                      input logic [31:0] w_raw, input logic [31:0] h_raw,
                      input logic [15:0] depth, input int unsigned bad_pct,
                      input int unsigned tail);
    build_file(sig, offset, w_raw, h_raw, depth, bad_pct, tail);
    send_file(1'b1, file_bytes.size());
  endtask

  // Sends only the first bytes of a file; the rest never arrives.
  task automatic play_part(input logic [15:0] sig, input logic [31:0] offset,
                           input logic [31:0] w_raw, input logic [31:0] h_raw,
                           input logic [15:0] depth, input int unsigned count);
    build_file(sig, offset, w_raw, h_raw, depth, 0, 0);
    send_file(1'b1, count);
  endtask

  initial begin
    int unsigned pick;
    int unsigned bad;
    int unsigned tail;
    int unsigned cut;
    logic [15:0] sig;
    logic [15:0] depth;
    logic [31:0] offset;
    logic [31:0] w_raw;
    logic [31:0] h_raw;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The first file after reset carries no start mark.
    build_file(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd3, 32'd2,
               bpsp_pkg::DEPTH_24, 0, 2);
    send_file(1'b0, file_bytes.size());
    play(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START + 6, 32'd2, 32'd2,
         bpsp_pkg::DEPTH_32, 0, 1);
    play(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd3, 32'd1,
         bpsp_pkg::DEPTH_32, 0, 0);
    play_part(16'h4E42, bpsp_pkg::POS_PIXEL_START, 32'd1, 32'd1, bpsp_pkg::DEPTH_24, 8);
    play_part(16'h4D43, bpsp_pkg::POS_PIXEL_START, 32'd1, 32'd1, bpsp_pkg::DEPTH_24, 6);
    play_part(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd2, 32'd2, 16'd8, 34);
    play_part(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd2, 32'd2, 16'h0118, 32);
    play_part(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, MAX_DIM + 1, 32'd1,
              bpsp_pkg::DEPTH_24, 26);
    play_part(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd2, 32'h7FFF_FFFF,
              bpsp_pkg::DEPTH_32, 30);
    play(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd0, 32'd3,
         bpsp_pkg::DEPTH_24, 0, 2);
    play(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd2, 32'hFFFF_FFFF,
         bpsp_pkg::DEPTH_24, 0, 0);
    play(bpsp_pkg::SIGNATURE, 32'd0, 32'h8000_0000, 32'd2, bpsp_pkg::DEPTH_24, 0, 0);
    play(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_HEADER_END, 32'd2, 32'd2,
         bpsp_pkg::DEPTH_24, 0, 1);
    play(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd2, 32'd2,
         bpsp_pkg::DEPTH_24, 100, 2);
    play(bpsp_pkg::SIGNATURE, 32'hFFFF_FFFF, 32'd1, 32'd1, bpsp_pkg::DEPTH_24, 0, 4);
    play(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd3, 32'd3,
         bpsp_pkg::DEPTH_24, 0, 0);
    // Images at the size limit: only their first pixels are sent.
    play_part(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, MAX_DIM, 32'd1,
              bpsp_pkg::DEPTH_24, 70);
    play_part(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd1, MAX_DIM,
              bpsp_pkg::DEPTH_24, 68);

    // Long receiver hold while a pixel-heavy image keeps coming in.
    hold_request = 1'b1;
    play(bpsp_pkg::SIGNATURE, bpsp_pkg::POS_PIXEL_START, 32'd4, 32'd3,
         bpsp_pkg::DEPTH_32, 0, 0);

    // Random files, mostly well formed, some broken in one specific way.
    while (sent_count < 1400) begin
      sig    = bpsp_pkg::SIGNATURE;
      depth  = $urandom_range(1) ? bpsp_pkg::DEPTH_32 : bpsp_pkg::DEPTH_24;
      offset = ($urandom_range(3) == 0) ? bpsp_pkg::POS_PIXEL_START + $urandom_range(8) :
                                          bpsp_pkg::POS_PIXEL_START;
      w_raw  = $urandom_range(6, 1);
      h_raw  = $urandom_range(4, 1);
      bad    = 2;
      tail   = $urandom_range(3);
      cut    = 0;
      pick   = $urandom_range(99);
      if (pick < 7) begin
        bad = 30;
      end else if (pick < 12) begin
        sig = 16'($urandom);
      end else if (pick < 17) begin
        depth = 16'($urandom);
      end else if (pick < 21) begin
        if ($urandom_range(1)) w_raw = $urandom_range(32'h7FFF_FFFF, MAX_DIM + 1);
        else h_raw = $urandom_range(32'h7FFF_FFFF, MAX_DIM + 1);
      end else if (pick < 25) begin
        if ($urandom_range(1)) w_raw = $urandom_range(1) ? 32'd0 : (32'h8000_0000 | $urandom);
        else h_raw = $urandom_range(1) ? 32'd0 : (32'h8000_0000 | $urandom);
      end else if (pick < 28) begin
        offset = $urandom_range(bpsp_pkg::POS_HEADER_END);
      end else if (pick < 35) begin
        // Cut short; the next file restarts the parse mid-stream.
        cut = $urandom_range(80, 2);
      end
      build_file(sig, offset, w_raw, h_raw, depth, bad, tail);
      if (cut == 0 || cut > file_bytes.size()) cut = file_bytes.size();
      send_file(1'b1, cut);
    end
    in_valid <= 1'b0;

    // Drain and give a late spurious result the chance to show up.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("PASS bmp_pixel_stream_parser");
    end else begin
      $display("FAIL bmp_pixel_stream_parser");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bpsp_pkg.sv
src/bpsp_parse_core.sv
src/bpsp_out_buffer.sv
src/bmp_pixel_stream_parser.sv
src/bpsp_checker.sv
tb/bmp_pixel_stream_parser_test.sv
